>>> rtl/tbsgc_pkg.sv
//------------------------------------------------------------------------------
// tbsgc_pkg
// Shared types and constants for the two-button scroll gesture controller.
//------------------------------------------------------------------------------
`default_nettype none

package tbsgc_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_ENABLE        = 3'd0,
		CFG_TOTAL_LINES   = 3'd1,
		CFG_DEBOUNCE_MS   = 3'd2,
		CFG_LONG_PRESS_MS = 3'd3,
		CFG_RESET_HOLD_MS = 3'd4
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TIME_W     = 32;
	localparam int LINE_W     = 16;

	// Register reset values
	localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [15:0] LONG_PRESS_RST = 16'd500;
	localparam logic [15:0] RESET_HOLD_RST = 16'd2000;

	// Flash codes
	typedef enum logic [1:0] {
		FLASH_NONE   = 2'd0,
		FLASH_TOP    = 2'd1,
		FLASH_BOTTOM = 2'd2
	} flash_t;

	// Configuration bundle
	typedef struct packed {
		logic        enable;
		logic [15:0] total_lines;
		logic [15:0] debounce_ms;
		logic [15:0] long_press_ms;
		logic [15:0] reset_hold_ms;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic [15:0] scroll_start;
		logic        redraw;
		flash_t      flash_code;
		logic        hold_notice;
		logic        reset_request;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/tbsgc_cfg.sv
//------------------------------------------------------------------------------
// tbsgc_cfg
// Configuration register file, written through a plain write port.
//------------------------------------------------------------------------------
`default_nettype none

module tbsgc_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [tbsgc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tbsgc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output tbsgc_pkg::cfg_t                          cfg
);

	tbsgc_pkg::cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable        <= 1'b0;
			cfg_q.total_lines   <= '0;
			cfg_q.debounce_ms   <= tbsgc_pkg::DEBOUNCE_RST;
			cfg_q.long_press_ms <= tbsgc_pkg::LONG_PRESS_RST;
			cfg_q.reset_hold_ms <= tbsgc_pkg::RESET_HOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tbsgc_pkg::CFG_ENABLE:        cfg_q.enable        <= cfg_data[0];
				tbsgc_pkg::CFG_TOTAL_LINES:   cfg_q.total_lines   <= cfg_data;
				tbsgc_pkg::CFG_DEBOUNCE_MS:   cfg_q.debounce_ms   <= cfg_data;
				tbsgc_pkg::CFG_LONG_PRESS_MS: cfg_q.long_press_ms <= cfg_data;
				tbsgc_pkg::CFG_RESET_HOLD_MS: cfg_q.reset_hold_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/tbsgc_core.sv
//------------------------------------------------------------------------------
// tbsgc_core
// Gesture state and the single-pass step logic for one button sample.
//------------------------------------------------------------------------------
`default_nettype none

module tbsgc_core #(
	parameter int VISIBLE_LINES = 12
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              step,
	input  wire tbsgc_pkg::cfg_t                   cfg,
	input  wire logic [tbsgc_pkg::TIME_W-1:0]      now_ms,
	input  wire logic                              up_down,
	input  wire logic                              down_down,
	output tbsgc_pkg::result_t                     res
);

	localparam logic [15:0] VIS = 16'(VISIBLE_LINES);

	// Gesture state
	logic        both_held_q, up_prev_q, down_prev_q, up_long_done_q, down_long_done_q;
	logic [31:0] both_start_q, up_press_q, down_press_q;
	logic [15:0] view_q;

	// Next-state values
	logic        both_held_d, up_prev_d, down_prev_d, up_long_done_d, down_long_done_d;
	logic [31:0] both_start_d, up_press_d, down_press_d;
	logic [15:0] view_d;

	logic [15:0] bottom;
	logic [31:0] both_age, up_age, down_age;

	assign bottom   = (cfg.total_lines > VIS) ? (cfg.total_lines - VIS) : 16'd0;
	assign both_age = now_ms - both_start_q;
	assign up_age   = now_ms - up_press_q;
	assign down_age = now_ms - down_press_q;

	// Step logic
	always_comb begin
		both_held_d      = both_held_q;
		both_start_d     = both_start_q;
		up_prev_d        = up_prev_q;
		down_prev_d      = down_prev_q;
		up_press_d       = up_press_q;
		down_press_d     = down_press_q;
		up_long_done_d   = up_long_done_q;
		down_long_done_d = down_long_done_q;
		view_d           = view_q;
		res.redraw        = 1'b0;
		res.flash_code    = tbsgc_pkg::FLASH_NONE;
		res.hold_notice   = 1'b0;
		res.reset_request = 1'b0;

		if (cfg.enable) begin
			if (up_down && down_down) begin
				// two-button hold
				if (!both_held_q) begin
					both_held_d     = 1'b1;
					both_start_d    = now_ms;
					res.hold_notice = 1'b1;
				end else if (both_age >= {16'd0, cfg.reset_hold_ms}) begin
					res.reset_request = 1'b1;
				end
			end else begin
				if (both_held_q) begin
					both_held_d = 1'b0;
					res.redraw  = 1'b1;
				end

				// button one: scroll up
				if (up_down && !up_prev_q) begin
					up_press_d     = now_ms;
					up_long_done_d = 1'b0;
				end else if (up_down && up_prev_q) begin
					if (!up_long_done_q && up_age >= {16'd0, cfg.long_press_ms}) begin
						view_d         = '0;
						res.flash_code = tbsgc_pkg::FLASH_TOP;
						res.redraw     = 1'b1;
						up_long_done_d = 1'b1;
					end
				end else if (!up_down && up_prev_q) begin
					if (!up_long_done_q && up_age >= {16'd0, cfg.debounce_ms}
							&& view_d != 16'd0) begin
						view_d     = view_d - 16'd1;
						res.redraw = 1'b1;
					end
				end

				// button two: scroll down (sees the result of button one)
				if (down_down && !down_prev_q) begin
					down_press_d     = now_ms;
					down_long_done_d = 1'b0;
				end else if (down_down && down_prev_q) begin
					if (!down_long_done_q && down_age >= {16'd0, cfg.long_press_ms}) begin
						view_d           = bottom;
						res.flash_code   = tbsgc_pkg::FLASH_BOTTOM;
						res.redraw       = 1'b1;
						down_long_done_d = 1'b1;
					end
				end else if (!down_down && down_prev_q) begin
					if (!down_long_done_q && down_age >= {16'd0, cfg.debounce_ms}
							&& view_d < bottom) begin
						view_d     = view_d + 16'd1;
						res.redraw = 1'b1;
					end
				end

				up_prev_d   = up_down;
				down_prev_d = down_down;
			end
		end
		res.scroll_start = view_d;
	end

	// State update on each transfer into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			both_held_q      <= 1'b0;
			both_start_q     <= '0;
			up_prev_q        <= 1'b1;
			down_prev_q      <= 1'b1;
			up_press_q       <= '0;
			down_press_q     <= '0;
			up_long_done_q   <= 1'b0;
			down_long_done_q <= 1'b0;
			view_q           <= '0;
		end else if (step) begin
			both_held_q      <= both_held_d;
			both_start_q     <= both_start_d;
			up_prev_q        <= up_prev_d;
			down_prev_q      <= down_prev_d;
			up_press_q       <= up_press_d;
			down_press_q     <= down_press_d;
			up_long_done_q   <= up_long_done_d;
			down_long_done_q <= down_long_done_d;
			view_q           <= view_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/two_button_scroll_gesture_controller.sv
// out_valid rises once a sample has passed the input register and then the result register.
// Throughput: one sample per cycle unless the result stalls; the state update happens
// in the single logic pass between the input register and the result register.
// A stalled result holds in the result register while the input register takes one more sample.
// Reset (arst_n low): registers at their defaults, both buttons treated as pressed,
// window start 0, no items in flight.
//------------------------------------------------------------------------------
// two_button_scroll_gesture_controller
// Short/long press scroll control from timestamped two-button samples.
//------------------------------------------------------------------------------
`default_nettype none

module two_button_scroll_gesture_controller #(
	parameter int VISIBLE_LINES = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// sample channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] now_ms,
	input  wire logic        up_down,
	input  wire logic        down_down,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      scroll_start,
	output logic             redraw,
	output logic [1:0]       flash_code,
	output logic             hold_notice,
	output logic             reset_request
);

	tbsgc_pkg::cfg_t    cfg;
	tbsgc_pkg::result_t res;
	tbsgc_pkg::result_t res_q;

	logic        valid_s1;
	logic [31:0] now_s1;
	logic        up_s1, down_s1;
	logic        out_valid_q;
	logic        step;

	// A sample moves on when the result register is empty or being drained
	assign step     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !step;

	tbsgc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			now_s1  <= now_ms;
			up_s1   <= up_down;
			down_s1 <= down_down;
		end
	end

	tbsgc_core #(
		.VISIBLE_LINES (VISIBLE_LINES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.cfg       (cfg),
		.now_ms    (now_s1),
		.up_down   (up_s1),
		.down_down (down_s1),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign scroll_start  = res_q.scroll_start;
	assign redraw        = res_q.redraw;
	assign flash_code    = res_q.flash_code;
	assign hold_notice   = res_q.hold_notice;
	assign reset_request = res_q.reset_request;

endmodule

`default_nettype wire
